/* rtl/scalru_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
package scalru_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int STAMP_BITS_DEF   = 32;

    // Fixed field widths
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 63;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Configuration register reset values
    localparam logic [2:0] SET_BITS_RST   = 3'd1;
    localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;

    // Access kinds; the fourth code behaves as a load
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOOK = 1'b1
    } state_t;

    // Input request
    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
    } req_t;

    // Result
    typedef struct packed {
        logic               first_hit;
        logic               first_miss;
        logic               evicted;
        logic               second_hit;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // request accepted: latch it and read its set
        logic commit;   // write the set back and load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy; // result register full and stalled
    } status_t;

endpackage

/* rtl/set_assoc_cache_lru_sim_unit.sv */
// Top level of the set-associative LRU cache model: controller plus datapath.
//
// Each request (load, store or modify at a byte address) is handled in order:
// the whole set row is read from the set memory, then its ways are searched,
// the row is written back and the result register is loaded. A modify's
// second access is folded into the same write-back. No new request is taken
// before the write-back; a request is taken while the previous result still
// waits in the result register, and the block holds in its lookup state only
// if that register is still full and stalled. No clearing pass is needed after
// reset. Configuration writes are always ready and take effect on the next
// request; they are to be made only while no request is in flight.
module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = scalru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = scalru_pkg::MAX_WAYS_DEF,
    parameter int STAMP_BITS   = scalru_pkg::STAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  scalru_pkg::req_t                    in_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output scalru_pkg::rsp_t                    out_rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scalru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scalru_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scalru_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes never wait
    assign cfg_ready = 1'b1;

    // Controller
    scalru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    scalru_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_req),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/scalru_ctrl.sv */
// Controller state machine: sequences the set read and the write-back.
module scalru_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  scalru_pkg::status_t status,
    output scalru_pkg::cmd_t    cmd
);
    import scalru_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // hold the looked-up set until the result slot frees up
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/scalru_dp.sv */
// Datapath: config registers, set memory, way search, totals and result register.
module scalru_dp #(
    parameter int MAX_SET_BITS = scalru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = scalru_pkg::MAX_WAYS_DEF,
    parameter int STAMP_BITS   = scalru_pkg::STAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scalru_pkg::req_t                    in_req,
    input  logic                                cfg_valid,
    input  logic [scalru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scalru_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output scalru_pkg::rsp_t                    out_rsp,
    input  scalru_pkg::cmd_t                    cmd,
    output scalru_pkg::status_t                 status
);
    import scalru_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

    // Configuration registers
    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Clamped configuration
    logic [4:0]        sb_eff;
    logic [5:0]        bb_eff;
    logic [WCNT_W-1:0] ways_eff;

    always_comb
    begin
        if (set_bits_reg == 3'd0)
            sb_eff = 5'd1;
        else if ({2'b00, set_bits_reg} > 5'(MAX_SET_BITS))
            sb_eff = 5'(MAX_SET_BITS);
        else
            sb_eff = {2'b00, set_bits_reg};

        if (block_bits_reg == 6'd0)
            bb_eff = 6'd1;
        else if (block_bits_reg > 6'd32)
            bb_eff = 6'd32;
        else
            bb_eff = block_bits_reg;

        if (ways_reg == 4'd0)
            ways_eff = WCNT_W'(1);
        else if ({2'b00, ways_reg} > 6'(MAX_WAYS))
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(ways_reg);
    end

    // Address split: set index and tag
    logic [ADDR_W-1:0]       set_shift;
    logic [ADDR_W-1:0]       tag_shift;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [MAX_SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]        tag_in;

    always_comb
    begin
        set_shift = in_req.address >> bb_eff;
        for (int i = 0; i < MAX_SET_BITS; i++)
        begin
            set_mask[i] = (5'(i) < sb_eff);
        end
        set_idx   = set_shift[MAX_SET_BITS-1:0] & set_mask;
        tag_shift = in_req.address >> (7'(bb_eff) + 7'(sb_eff));
        tag_in    = tag_shift[TAG_W-1:0];
    end

    // Set memory, one row per set; way valid bits live in the row
    logic [MAX_WAYS-1:0]                  mem_vld   [NUM_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]       mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  mem_stamp [NUM_SETS];

    logic [MAX_WAYS-1:0]                  rd_vld_reg;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag_reg;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  rd_stamp_reg;

    logic [MAX_WAYS-1:0]                  wr_vld;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       wr_tag;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  wr_stamp;

    // Captured request
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic                    modify_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_vld_reg   <= mem_vld[set_idx];
            rd_tag_reg   <= mem_tag[set_idx];
            rd_stamp_reg <= mem_stamp[set_idx];
            set_reg      <= set_idx;
            tag_reg      <= tag_in;
            modify_reg   <= (in_req.kind == KIND_MODIFY);
        end
        if (cmd.commit)
        begin
            mem_vld[set_reg]   <= wr_vld;
            mem_tag[set_reg]   <= wr_tag;
            mem_stamp[set_reg] <= wr_stamp;
        end
    end

    // Row-written flags (an unwritten row reads as all ways empty) and time
    logic [NUM_SETS-1:0]   row_init_reg;
    logic                  row_ok_reg;
    logic [STAMP_BITS-1:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
            row_ok_reg   <= 1'b0;
            time_reg     <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                row_ok_reg <= row_init_reg[set_idx];
                time_reg   <= time_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                row_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    // Way search: lowest hit, highest empty, oldest valid (ties to lowest)
    logic [MAX_WAYS-1:0]   base_vld;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   live;
    logic [MAX_WAYS-1:0]   hit_vec;
    logic                  hit;
    logic [WAY_W-1:0]      hit_way;
    logic                  have_empty;
    logic [WAY_W-1:0]      empty_way;
    logic                  have_old;
    logic [WAY_W-1:0]      old_way;
    logic [STAMP_BITS-1:0] old_stamp;
    logic [WAY_W-1:0]      target;
    logic                  evict;

    always_comb
    begin
        base_vld = row_ok_reg ? rd_vld_reg : '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]  = (WCNT_W'(w) < ways_eff);
            live[w]    = base_vld[w] & in_use[w];
            hit_vec[w] = live[w] & (rd_tag_reg[w] == tag_reg);
        end
        hit = |hit_vec;

        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
                hit_way = WAY_W'(w);
        end

        have_empty = 1'b0;
        empty_way  = '0;
        have_old   = 1'b0;
        old_way    = '0;
        old_stamp  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && !live[w])
            begin
                have_empty = 1'b1;
                empty_way  = WAY_W'(w);
            end
            if (live[w] && (!have_old || rd_stamp_reg[w] < old_stamp))
            begin
                have_old  = 1'b1;
                old_way   = WAY_W'(w);
                old_stamp = rd_stamp_reg[w];
            end
        end

        evict = !hit && !have_empty;
        if (hit)
            target = hit_way;
        else if (have_empty)
            target = empty_way;
        else
            target = old_way;

        // Write-back row: target line gets the tag and the current time
        wr_vld           = base_vld;
        wr_tag           = rd_tag_reg;
        wr_stamp         = rd_stamp_reg;
        wr_vld[target]   = 1'b1;
        wr_tag[target]   = tag_reg;
        wr_stamp[target] = time_reg;
    end

    // Saturating totals
    logic [TOTAL_W-1:0] hits_reg;
    logic [TOTAL_W-1:0] misses_reg;
    logic [TOTAL_W-1:0] evicts_reg;
    logic [TOTAL_W-1:0] hits_next;
    logic [TOTAL_W-1:0] misses_next;
    logic [TOTAL_W-1:0] evicts_next;
    logic [1:0]         hit_inc;
    logic [TOTAL_W:0]   hit_sum;
    logic [TOTAL_W:0]   miss_sum;
    logic [TOTAL_W:0]   evict_sum;

    always_comb
    begin
        // a modify's second access always hits
        hit_inc     = 2'(hit) + 2'(modify_reg);
        hit_sum     = {1'b0, hits_reg} + (TOTAL_W + 1)'(hit_inc);
        miss_sum    = {1'b0, misses_reg} + (TOTAL_W + 1)'(!hit);
        evict_sum   = {1'b0, evicts_reg} + (TOTAL_W + 1)'(evict);
        hits_next   = hit_sum[TOTAL_W]   ? '1 : hit_sum[TOTAL_W-1:0];
        misses_next = miss_sum[TOTAL_W]  ? '1 : miss_sum[TOTAL_W-1:0];
        evicts_next = evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
    end

    // Totals and result register
    logic out_valid_reg;
    rsp_t out_rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evicts_reg    <= evicts_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_rsp_reg.first_hit       <= hit;
            out_rsp_reg.first_miss      <= !hit;
            out_rsp_reg.evicted         <= evict;
            out_rsp_reg.second_hit      <= modify_reg;
            out_rsp_reg.total_hits      <= hits_next;
            out_rsp_reg.total_misses    <= misses_next;
            out_rsp_reg.total_evictions <= evicts_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_rsp         = out_rsp_reg;
    assign status.out_busy = out_valid_reg & out_stall;

endmodule

/* rtl/scalru_chk.sv */
// Port-level checker for the cache model, bound to the top level.
module scalru_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input scalru_pkg::rsp_t                    out_rsp
);
    import scalru_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_rsp))
        else $error("stalled result changed");

    // One request at a time: the cycle after an accept is stalled
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted during lookup");

    // A fresh result traces back to an accepted request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a request");

    // Exactly one of hit and miss; eviction only on a miss
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rsp.first_hit != out_rsp.first_miss) &&
                      !(out_rsp.evicted && !out_rsp.first_miss))
        else $error("inconsistent hit, miss and eviction flags");

endmodule

bind set_assoc_cache_lru_sim_unit scalru_chk u_chk (.*);

/* tb/tb_set_assoc_cache_lru_sim_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative LRU cache model top level.
module tb_set_assoc_cache_lru_sim_unit;
    import scalru_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS_DEF;
    localparam int NUM_LINES = NUM_SETS * MAX_WAYS_DEF;
    localparam int MAX_BLOCK_BITS = 32;
    localparam int MAX_GAP = 19;
    localparam int LONG_HOLD = 80;
    localparam int POOL_SIZE = 12;
    localparam longint RUN_LIMIT_NS = 5_000_000;
    // Fourth access code, handled as a load
    localparam logic [1:0] KIND_LOAD_ALIAS = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_req;
    logic out_valid;
    logic out_stall;
    rsp_t out_rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the configuration registers
    logic [2:0] cfg_set_bits;
    logic [5:0] cfg_block_bits;
    logic [3:0] cfg_ways;

    // Mirror of the cache store, access clock and totals
    logic way_valid [NUM_LINES];
    logic [TAG_W-1:0] way_tag [NUM_LINES];
    logic [STAMP_BITS_DEF-1:0] way_stamp [NUM_LINES];
    logic [STAMP_BITS_DEF-1:0] access_clock;
    logic [TOTAL_W-1:0] hit_count;
    logic [TOTAL_W-1:0] miss_count;
    logic [TOTAL_W-1:0] evict_count;

    // Results predicted for accepted requests, oldest first
    rsp_t awaited_results[$];

    bit tx_paced;
    bit rx_paced;
    int long_hold_cycles;
    int requests_sent;
    int results_checked;
    int mismatch_count;
    int geometry_count;
    logic [63:0] tag_pool [POOL_SIZE];

    set_assoc_cache_lru_sim_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_range(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [TOTAL_W-1:0] saturating_inc(logic [TOTAL_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // One lookup in a set: refresh on hit, else fill highest empty way or evict LRU
    function automatic bit probe_set(int set_idx, logic [TAG_W-1:0] tag, int ways,
                                     output bit replaced);
        int base;
        int oldest;
        int empty_way;
        int slot;
        bit have_oldest;
        bit have_empty;
        base = set_idx * MAX_WAYS_DEF;
        oldest = 0;
        empty_way = 0;
        have_oldest = 1'b0;
        have_empty = 1'b0;
        replaced = 1'b0;
        for (int w = 0; w < ways; w++)
        begin
            if (!way_valid[base + w])
            begin
                empty_way = w;
                have_empty = 1'b1;
            end
            else if (way_tag[base + w] == tag)
            begin
                way_stamp[base + w] = access_clock;
                hit_count = saturating_inc(hit_count);
                return 1'b1;
            end
            else if (!have_oldest || way_stamp[base + w] < way_stamp[base + oldest])
            begin
                oldest = w;
                have_oldest = 1'b1;
            end
        end
        slot = base + (have_empty ? empty_way : oldest);
        if (!have_empty)
        begin
            replaced = 1'b1;
            evict_count = saturating_inc(evict_count);
        end
        way_valid[slot] = 1'b1;
        way_tag[slot] = tag;
        way_stamp[slot] = access_clock;
        miss_count = saturating_inc(miss_count);
        return 1'b0;
    endfunction

    // Expected result of one request under the current geometry
    function automatic rsp_t predict_access(req_t r);
        int sb;
        int bb;
        int ways;
        int set_idx;
        logic [TAG_W-1:0] tag;
        bit first;
        bit second;
        bit replaced;
        bit unused_replace;
        rsp_t res;
        sb = clamp_range(cfg_set_bits, 1, MAX_SET_BITS_DEF);
        bb = clamp_range(cfg_block_bits, 1, MAX_BLOCK_BITS);
        ways = clamp_range(cfg_ways, 1, MAX_WAYS_DEF);
        set_idx = int'((r.address >> bb) & ((64'd1 << sb) - 64'd1));
        tag = TAG_W'(r.address >> (bb + sb));
        access_clock = access_clock + 1'b1;
        first = probe_set(set_idx, tag, ways, replaced);
        second = 1'b0;
        if (r.kind == KIND_MODIFY)
            second = probe_set(set_idx, tag, ways, unused_replace);
        res.first_hit = first;
        res.first_miss = !first;
        res.evicted = replaced;
        res.second_hit = second;
        res.total_hits = hit_count;
        res.total_misses = miss_count;
        res.total_evictions = evict_count;
        return res;
    endfunction

    // Address built from a small tag pool so that lines get reused and evicted
    function automatic logic [63:0] random_address(int tag_span, int set_span);
        int sb;
        int bb;
        logic [63:0] tag;
        logic [63:0] set_sel;
        logic [63:0] offset;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        sb = clamp_range(cfg_set_bits, 1, MAX_SET_BITS_DEF);
        bb = clamp_range(cfg_block_bits, 1, MAX_BLOCK_BITS);
        tag = tag_pool[$urandom_range(0, tag_span - 1)];
        set_sel = 64'($urandom_range(0, set_span - 1)) & ((64'd1 << sb) - 64'd1);
        offset = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
        return (tag << (bb + sb)) | (set_sel << bb) | offset;
    endfunction

    // Send one request; valid stays high on return so back-to-back requests need no gap
    task automatic send_request(req_t r);
        int gap;
        gap = tx_paced ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(predict_access(r));
        requests_sent++;
    endtask

    task automatic send_item(kind_t k, logic [63:0] a);
        req_t r;
        r.kind = k;
        r.address = a;
        send_request(r);
    endtask

    task automatic send_random(int count, int tag_span, int set_span);
        req_t r;
        repeat (count)
        begin
            r.kind = kind_t'(2'($urandom_range(0, 3)));
            r.address = random_address(tag_span, set_span);
            send_request(r);
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; valid is left high for the next write
    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SET_BITS:   cfg_set_bits = value[2:0];
            CFG_BLOCK_BITS: cfg_block_bits = value;
            CFG_WAYS:       cfg_ways = value[3:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [5:0] sb_raw, logic [5:0] bb_raw, logic [5:0] ways_raw);
        write_register(CFG_SET_BITS, sb_raw);
        write_register(CFG_BLOCK_BITS, bb_raw);
        write_register(CFG_WAYS, ways_raw);
        cfg_valid <= 1'b0;
        geometry_count++;
    endtask

    task automatic new_tag_pool();
        foreach (tag_pool[i])
            tag_pool[i] = {$urandom, $urandom};
    endtask

    task automatic set_pacing(bit tx, bit rx);
        tx_paced = tx;
        rx_paced = rx;
    endtask

    // Hits, misses, LRU evictions, modify, the load alias and extreme addresses
    task automatic test_directed_sequence();
        set_geometry(6'd2, 6'd4, 6'd2);
        set_pacing(1'b0, 1'b0);
        send_item(KIND_LOAD, 64'h0000_0000_0000_0000);
        send_item(KIND_LOAD, 64'h0000_0000_0000_000F);
        send_item(KIND_STORE, 64'h0000_0000_0000_0040);
        send_item(KIND_LOAD, 64'h0000_0000_0000_0080);
        send_item(KIND_LOAD, 64'h0000_0000_0000_0000);
        send_item(KIND_MODIFY, 64'h0000_0000_0000_00C0);
        send_item(KIND_MODIFY, 64'h0000_0000_0000_00C8);
        send_item(kind_t'(KIND_LOAD_ALIAS), 64'h0000_0000_0000_00C0);
        send_item(kind_t'(KIND_LOAD_ALIAS), 64'h0000_0000_0000_0100);
        send_item(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFF0);
        send_item(KIND_MODIFY, 64'h8000_0000_0000_0030);
        send_item(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_LOAD, 64'h0000_0000_0000_0010);
        send_item(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_STORE, 64'h5555_5555_5555_5555);
        send_item(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_MODIFY, 64'h5555_5555_5555_5555);
        send_item(KIND_STORE, 64'h8000_0000_0000_0000);
        send_item(KIND_LOAD, 64'h0000_0000_0000_0040);
        wait_idle();
    endtask

    // Register values outside the meaningful range are masked and clamped
    task automatic test_register_limits();
        new_tag_pool();
        set_pacing(1'b1, 1'b0);
        set_geometry(6'h00, 6'h00, 6'h00);
        send_random(30, 6, 2);
        wait_idle();
        set_geometry(6'h07, 6'h21, 6'h09);
        send_random(40, 12, 3);
        wait_idle();
        set_geometry(6'h3F, 6'h3F, 6'h0F);
        send_random(40, 12, 2);
        wait_idle();
        set_geometry(6'h08, 6'd32, 6'h10);
        send_random(30, 4, 2);
        wait_idle();
    endtask

    // Lines survive a geometry change; ways above the new count are left alone
    task automatic test_resize_while_warm();
        new_tag_pool();
        set_pacing(1'b0, 1'b1);
        set_geometry(6'd2, 6'd4, 6'd8);
        send_random(60, 12, 2);
        wait_idle();
        set_geometry(6'd2, 6'd4, 6'd2);
        send_random(60, 12, 2);
        wait_idle();
        set_geometry(6'd2, 6'd4, 6'd8);
        send_random(60, 12, 2);
        wait_idle();
        set_geometry(6'd3, 6'd5, 6'd8);
        send_random(40, 12, 3);
        wait_idle();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        new_tag_pool();
        set_pacing(1'b0, 1'b0);
        set_geometry(6'd3, 6'd6, 6'd4);
        long_hold_cycles = LONG_HOLD;
        send_random(16, 8, 2);
        wait_idle();
    endtask

    task automatic random_phase(logic [5:0] sb, logic [5:0] bb, logic [5:0] ways,
                                bit tx, bit rx);
        new_tag_pool();
        set_pacing(tx, rx);
        set_geometry(sb, bb, ways);
        send_random(194, $urandom_range(2, POOL_SIZE), $urandom_range(1, 4));
        wait_idle();
    endtask

    // Random traffic over several geometries, extremes included
    task automatic test_random_traffic();
        random_phase(6'd1, 6'd1, 6'd1, 1'b0, 1'b0);
        random_phase(6'd6, 6'd32, 6'd8, 1'b1, 1'b0);
        random_phase(6'd3, 6'd8, 6'd4, 1'b0, 1'b1);
        random_phase(6'd2, 6'd4, 6'd2, 1'b1, 1'b1);
        random_phase(6'd1, 6'd5, 6'd8, 1'b0, 1'b0);
        random_phase(6'd6, 6'd1, 6'd1, 1'b1, 1'b0);
        random_phase(6'd4, 6'd12, 6'd3, 1'b0, 1'b1);
        random_phase(6'd5, 6'd20, 6'd6, 1'b1, 1'b1);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Result receiver: random hold-off after each taken result when paced, plus long holds
    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                stall_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else if (out_valid && !out_stall)
                stall_left = rx_paced ? $urandom_range(0, MAX_GAP) : 0;
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : result_checker
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, out_rsp);
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                compare_field("first_hit", want.first_hit, out_rsp.first_hit);
                compare_field("first_miss", want.first_miss, out_rsp.first_miss);
                compare_field("evicted", want.evicted, out_rsp.evicted);
                compare_field("second_hit", want.second_hit, out_rsp.second_hit);
                compare_field("total_hits", want.total_hits, out_rsp.total_hits);
                compare_field("total_misses", want.total_misses, out_rsp.total_misses);
                compare_field("total_evictions", want.total_evictions,
                              out_rsp.total_evictions);
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t ns: run limit reached, %0d results outstanding",
                 $time, awaited_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, then the tests in turn
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cfg_set_bits = SET_BITS_RST;
        cfg_block_bits = BLOCK_BITS_RST;
        cfg_ways = WAYS_RST;
        foreach (way_valid[i])
        begin
            way_valid[i] = 1'b0;
            way_tag[i] = '0;
            way_stamp[i] = '0;
        end
        access_clock = '0;
        hit_count = '0;
        miss_count = '0;
        evict_count = '0;
        tx_paced = 1'b0;
        rx_paced = 1'b0;
        long_hold_cycles = 0;
        requests_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        geometry_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sequence();
        test_register_limits();
        test_resize_while_warm();
        test_output_backpressure();
        test_random_traffic();

        repeat (8) @(posedge clk);
        $display("Checked %0d of %0d requests over %0d register settings, with clamped",
                 results_checked, requests_sent, geometry_count);
        $display(
            "registers, resizing and a long stall (%0d hits, %0d misses, %0d evictions).",
            hit_count, miss_count, evict_count);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/scalru_pkg.sv
rtl/scalru_ctrl.sv
rtl/scalru_dp.sv
rtl/set_assoc_cache_lru_sim_unit.sv
rtl/scalru_chk.sv
tb/tb_set_assoc_cache_lru_sim_unit.sv
